// ===== sv/sbf_pkg.sv =====
package sbf_pkg;

	localparam int WORD_BITS_DEF = 8;
	localparam int BYTE_W = 8;
	localparam int QDEPTH = 2;

	localparam logic [1:0] OP_FULL  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [BYTE_W-1:0] tx_byte;
		logic [BYTE_W-1:0] miso_bits;
		logic              open_frame;
		logic              close_frame;
	} in_item_t;

	typedef struct packed {
		logic              csn_level;
		logic              sck_level;
		logic              mosi_level;
		logic [BYTE_W-1:0] rx_byte;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic              drive;
		logic              sample;
		logic              open_frame;
		logic              close_frame;
		logic [BYTE_W-1:0] tx_byte;
		logic [BYTE_W-1:0] miso_bits;
	} cmd_t;

	// bit positions at or above the byte width read as zero
	function automatic logic bit_sel(input logic [BYTE_W-1:0] v, input logic [31:0] i);
		logic r;
		r = 1'b0;
		if (i < 32'(BYTE_W)) begin
			r = v[i[$clog2(BYTE_W)-1:0]];
		end
		return r;
	endfunction

	function automatic logic [BYTE_W-1:0] bit_set(input logic [BYTE_W-1:0] v,
			input logic [31:0] i, input logic b);
		logic [BYTE_W-1:0] r;
		r = v;
		if (i < 32'(BYTE_W)) begin
			r[i[$clog2(BYTE_W)-1:0]] = v[i[$clog2(BYTE_W)-1:0]] | b;
		end
		return r;
	endfunction

endpackage

// ===== sv/sbf_front.sv =====
module sbf_front import sbf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	output logic     cmd_valid,
	output cmd_t     cmd,
	input  logic     pop
);

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	cmd_t          slot_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	cmd_t          cmd_in;
	logic          push;

	assign in_ready  = (cnt_q != CW'(QDEPTH));
	assign push      = in_valid && in_ready;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = slot_q[rd_ptr_q];

	always_comb begin
		cmd_in.drive       = (in_data.op != OP_READ);
		cmd_in.sample      = (in_data.op != OP_WRITE);
		cmd_in.open_frame  = in_data.open_frame;
		cmd_in.close_frame = in_data.close_frame;
		cmd_in.tx_byte     = in_data.tx_byte;
		cmd_in.miso_bits   = in_data.miso_bits;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/sbf_back.sv =====
module sbf_back import sbf_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int IW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam logic [IW-1:0] IDX_TOP = IW'(WORD_BITS - 1);

	localparam logic [2:0] PH_START = 3'd0;
	localparam logic [2:0] PH_OPEN  = 3'd1;
	localparam logic [2:0] PH_HI    = 3'd2;
	localparam logic [2:0] PH_LO    = 3'd3;
	localparam logic [2:0] PH_CLOSE = 3'd4;

	logic [2:0]        phase_q, phase_d, eff_phase;
	logic [IW-1:0]     idx_q, idx_d;
	logic              csn_q, csn_d;
	logic              mosi_q, mosi_d;
	logic [BYTE_W-1:0] rx_q, rx_d;
	logic              out_valid_q;
	out_item_t         out_q, res;
	logic              advance;
	logic              pop_c;
	logic              bit_tx;
	logic              bit_rx;

	assign advance   = cmd_valid && (!out_valid_q || out_ready);
	assign pop       = advance && pop_c;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign bit_tx    = bit_sel(cmd.tx_byte, 32'(idx_q));
	assign bit_rx    = bit_sel(cmd.miso_bits, 32'(idx_q));

	always_comb begin
		eff_phase = phase_q;
		if (phase_q == PH_START) begin
			eff_phase = cmd.open_frame ? PH_OPEN : PH_HI;
		end
		phase_d        = phase_q;
		idx_d          = idx_q;
		csn_d          = csn_q;
		mosi_d         = mosi_q;
		rx_d           = rx_q;
		pop_c          = 1'b0;
		res.csn_level  = csn_q;
		res.sck_level  = 1'b0;
		res.mosi_level = mosi_q;
		res.rx_byte    = '0;
		res.last       = 1'b0;
		unique case (eff_phase)
			PH_OPEN: begin
				csn_d         = 1'b0;
				res.csn_level = 1'b0;
				idx_d         = IDX_TOP;
				phase_d       = PH_HI;
			end
			PH_HI: begin
				if (cmd.drive) begin
					mosi_d = bit_tx;
				end
				res.mosi_level = mosi_d;
				res.sck_level  = 1'b1;
				if (cmd.sample) begin
					rx_d = bit_set(rx_q, 32'(idx_q), bit_rx);
				end
				phase_d = PH_LO;
			end
			PH_LO: begin
				if (idx_q == '0) begin
					if (cmd.close_frame) begin
						phase_d = PH_CLOSE;
					end else begin
						res.last    = 1'b1;
						res.rx_byte = rx_q;
						pop_c       = 1'b1;
						rx_d        = '0;
						idx_d       = IDX_TOP;
						phase_d     = PH_START;
					end
				end else begin
					idx_d   = idx_q - 1'b1;
					phase_d = PH_HI;
				end
			end
			PH_CLOSE: begin
				csn_d         = 1'b1;
				res.csn_level = 1'b1;
				res.last      = 1'b1;
				res.rx_byte   = rx_q;
				pop_c         = 1'b1;
				rx_d          = '0;
				idx_d         = IDX_TOP;
				phase_d       = PH_START;
			end
			default: begin
				phase_d = PH_START;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			idx_q       <= IDX_TOP;
			csn_q       <= 1'b1;
			mosi_q      <= 1'b0;
			rx_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_d;
				idx_q       <= idx_d;
				csn_q       <= csn_d;
				mosi_q      <= mosi_d;
				rx_q        <= rx_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/spi_master_byte_framer.sv =====
// An accepted item is queued, then its first pin beat is registered for output.
// Each item yields 2*WORD_BITS pin beats, plus one for each frame flag set
// (16 to 18 by default), one pin beat per cycle from the sequencer unless stalled.
// A two-entry queue takes the next item while the current one is clocked out.
// Reset: chip select high, MOSI low, queue and output register empty.
module spi_master_byte_framer import sbf_pkg::*; #(
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	logic cmd_valid;
	cmd_t cmd;
	logic pop;

	sbf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop)
	);

	sbf_back #(
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	a_sck_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.sck_level |-> !out_data.last)
		else $error("sck high on final beat");

	a_rx_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.rx_byte != '0) |-> out_data.last)
		else $error("received byte on non-final beat");

	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cmd_valid)
		else $error("pop from empty queue");

	a_pop_emits_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid && out_data.last)
		else $error("pop without final beat");

endmodule
